/* design/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants, microcode ROM and CRC byte step for the command
// frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    // Transaction payloads
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] argument;
    } in_item_t;

    typedef struct packed {
        logic [31:0] frame_word;
        logic        last_word;
    } out_item_t;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LENS_MOTOR = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRACKET    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 8'd7;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [31:0] nonce_word;
        logic [23:0] battery_reg_addr;
        logic [23:0] rssi_reg_addr;
        logic [23:0] distance_reg_addr;
        logic [23:0] lens_motor_reg_addr;
        logic [23:0] bracket_reg_addr;
        logic [23:0] volume_reg_addr;
    } cfg_t;

    localparam logic [31:0] SYNC_RESET       = 32'h4445_4354;
    localparam logic [31:0] NONCE_RESET      = 32'h1234_5678;
    localparam logic [23:0] BATTERY_RESET    = 24'h00_0001;
    localparam logic [23:0] RSSI_RESET       = 24'h00_0002;
    localparam logic [23:0] DISTANCE_RESET   = 24'h00_0003;
    localparam logic [23:0] LENS_MOTOR_RESET = 24'h80_0004;
    localparam logic [23:0] BRACKET_RESET    = 24'h80_0005;
    localparam logic [23:0] VOLUME_RESET     = 24'h80_0006;

    // Opcodes
    localparam logic [2:0] OP_BATTERY    = 3'd0;
    localparam logic [2:0] OP_RSSI       = 3'd1;
    localparam logic [2:0] OP_DISTANCE   = 3'd2;
    localparam logic [2:0] OP_AUTOFOCUS  = 3'd3;
    localparam logic [2:0] OP_LENS_MOTOR = 3'd4;
    localparam logic [2:0] OP_BRACKET    = 3'd5;
    localparam logic [2:0] OP_VOLUME     = 3'd6;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    // Bracket directions
    localparam logic [31:0] DIR_UP    = 32'd0;
    localparam logic [31:0] DIR_LEFT  = 32'd1;
    localparam logic [31:0] DIR_RIGHT = 32'd2;
    localparam logic [31:0] DIR_DOWN  = 32'd3;

    // Fixed frame words
    localparam logic [31:0] FRAME_LEN_WORD   = 32'd16;
    localparam logic [7:0]  DEVICE_ADDR      = 8'h01;
    localparam logic [31:0] READ_DATA        = 32'h0000_0001;
    localparam logic [31:0] AUTOFOCUS_DATA   = 32'hFFFF_0000;
    localparam logic [31:0] DATA_1_1         = 32'h0101_0001;
    localparam logic [31:0] DATA_1_2         = 32'h0102_0001;
    localparam logic [31:0] DATA_2_1         = 32'h0201_0001;
    localparam logic [31:0] DATA_2_2         = 32'h0202_0001;

    // CRC-32, IEEE reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Word source select
    localparam logic [2:0] SEL_NONE  = 3'd0;
    localparam logic [2:0] SEL_SYNC  = 3'd1;
    localparam logic [2:0] SEL_LEN   = 3'd2;
    localparam logic [2:0] SEL_NONCE = 3'd3;
    localparam logic [2:0] SEL_ADDR  = 3'd4;
    localparam logic [2:0] SEL_DATA  = 3'd5;
    localparam logic [2:0] SEL_CRC   = 3'd6;

    // Jump conditions
    localparam logic COND_NONE   = 1'b0;
    localparam logic COND_NODATA = 1'b1;

    // Microcode
    localparam int PC_W = 5;

    typedef struct packed {
        logic [2:0]      sel;     // word source, SEL_NONE = keep shifting
        logic            emit;    // push selected word to the output
        logic            init;    // restart the CRC from all ones
        logic            absorb;  // fold one byte into the CRC
        logic            last;    // tag emitted word as end of frame
        logic            cond;    // jump condition
        logic            done;    // end of program
        logic [PC_W-1:0] target;  // jump target
    } ucode_t;

    // Control handed from sequencer to datapath
    typedef struct packed {
        logic       fire;
        logic [2:0] sel;
        logic       emit;
        logic       init;
        logic       absorb;
        logic       last;
    } step_t;

    localparam logic [PC_W-1:0] UC_SYNC  = 5'd0;
    localparam logic [PC_W-1:0] UC_LEN   = 5'd4;
    localparam logic [PC_W-1:0] UC_NONCE = 5'd8;
    localparam logic [PC_W-1:0] UC_ADDR  = 5'd12;
    localparam logic [PC_W-1:0] UC_SKIP  = 5'd15;
    localparam logic [PC_W-1:0] UC_DATA  = 5'd16;
    localparam logic [PC_W-1:0] UC_CRC   = 5'd20;

    // One word step loads and absorbs its top byte; three more steps
    // absorb the rest.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t cw;
        cw = '{sel: SEL_NONE, emit: 1'b0, init: 1'b0, absorb: 1'b1, last: 1'b0,
               cond: COND_NONE, done: 1'b0, target: UC_SYNC};
        unique case (pc) inside
            UC_SYNC: begin
                cw.sel  = SEL_SYNC;
                cw.emit = 1'b1;
                cw.init = 1'b1;
            end
            UC_LEN: begin
                cw.sel  = SEL_LEN;
                cw.emit = 1'b1;
            end
            UC_NONCE: begin
                cw.sel  = SEL_NONCE;
                cw.emit = 1'b1;
            end
            UC_ADDR: begin
                cw.sel  = SEL_ADDR;
                cw.emit = 1'b1;
            end
            UC_SKIP: begin
                cw.cond   = COND_NODATA;
                cw.target = UC_CRC;
            end
            UC_DATA: begin
                cw.sel  = SEL_DATA;
                cw.emit = 1'b1;
            end
            UC_CRC: begin
                cw.sel    = SEL_CRC;
                cw.emit   = 1'b1;
                cw.absorb = 1'b0;
                cw.last   = 1'b1;
                cw.done   = 1'b1;
            end
            [UC_SYNC + 5'd1 : UC_LEN - 5'd1],
            [UC_LEN + 5'd1 : UC_NONCE - 5'd1],
            [UC_NONCE + 5'd1 : UC_ADDR - 5'd1],
            [UC_ADDR + 5'd1 : UC_SKIP - 5'd1],
            [UC_DATA + 5'd1 : UC_CRC - 5'd1]: begin
                cw.sel = SEL_NONE;
            end
            default: begin
                cw.absorb = 1'b0;
                cw.done   = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

/* design/command_frame_builder_crc32.sv */
// ----------------------------------------------------------------------------
// command_frame_builder_crc32
// Builds a CRC-32 terminated command frame of 32-bit words from one command.
// ----------------------------------------------------------------------------
// An accepted command sets the sequencer busy, and the first word then goes into the output register.
// A new command waits until the CRC word is handed off; a frame has 6 words, or 5 when the bracket
//   direction is out of range. The CRC absorbs one byte a cycle except while an emit step is stalled.
// Opcode 7 is dropped in its accept cycle and produces no transaction.
// Reset (aresetn low, synchronous): sequencer idle, output empty, config
//   registers back to their defaults.
module command_frame_builder_crc32 (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cfb_pkg::in_item_t             s_data,
    // frame word output
    output logic                          m_valid,
    input  logic                          m_ready,
    output cfb_pkg::out_item_t            m_data,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    cfb_pkg::cfg_t  cfg;
    cfb_pkg::step_t step;
    logic           busy;
    logic           has_data;
    logic           out_free;
    logic           s_accept;
    logic           start;

    // New command only once the previous frame has handed off its CRC word;
    // that word may still sit in the output register.
    assign s_ready  = !busy;
    assign s_accept = s_valid && s_ready;
    // unused opcode is swallowed without starting the program
    assign start    = s_accept && (s_data.opcode != cfb_pkg::OP_UNUSED);

    cfb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Program: per word, one load+emit step then three CRC byte steps, and one emit step for the CRC word;
    // a jump on the address word's last byte step skips the data word when absent.
    cfb_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .has_data (has_data),
        .out_free (out_free),
        .busy     (busy),
        .step     (step)
    );

    cfb_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .load     (start),
        .cmd      (s_data),
        .has_data (has_data),
        .step     (step),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* design/cfb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cfb_cfg_regs
// Configuration register file; writes to unlisted indexes are dropped.
// ----------------------------------------------------------------------------
module cfb_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output cfb_pkg::cfg_t                 cfg
);

    cfb_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cfb_pkg::REG_SYNC:       cfg_next.sync_word           = cfg_data;
                cfb_pkg::REG_NONCE:      cfg_next.nonce_word          = cfg_data;
                cfb_pkg::REG_BATTERY:    cfg_next.battery_reg_addr    = cfg_data[23:0];
                cfb_pkg::REG_RSSI:       cfg_next.rssi_reg_addr       = cfg_data[23:0];
                cfb_pkg::REG_DISTANCE:   cfg_next.distance_reg_addr   = cfg_data[23:0];
                cfb_pkg::REG_LENS_MOTOR: cfg_next.lens_motor_reg_addr = cfg_data[23:0];
                cfb_pkg::REG_BRACKET:    cfg_next.bracket_reg_addr    = cfg_data[23:0];
                cfb_pkg::REG_VOLUME:     cfg_next.volume_reg_addr     = cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_word           <= cfb_pkg::SYNC_RESET;
            cfg_reg.nonce_word          <= cfb_pkg::NONCE_RESET;
            cfg_reg.battery_reg_addr    <= cfb_pkg::BATTERY_RESET;
            cfg_reg.rssi_reg_addr       <= cfb_pkg::RSSI_RESET;
            cfg_reg.distance_reg_addr   <= cfb_pkg::DISTANCE_RESET;
            cfg_reg.lens_motor_reg_addr <= cfb_pkg::LENS_MOTOR_RESET;
            cfg_reg.bracket_reg_addr    <= cfb_pkg::BRACKET_RESET;
            cfg_reg.volume_reg_addr     <= cfb_pkg::VOLUME_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/cfb_sequencer.sv */
// ----------------------------------------------------------------------------
// cfb_sequencer
// Step counter over the microcode ROM with a conditional jump and output stall.
// ----------------------------------------------------------------------------
module cfb_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,     // frame-producing transaction accepted
    input  logic           has_data,  // data word present in this frame
    input  logic           out_free,  // output register can take a word
    output logic           busy,
    output cfb_pkg::step_t step
);

    logic [cfb_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     busy_reg, busy_next;
    logic                     has_data_reg, has_data_next;
    cfb_pkg::ucode_t          cw;
    logic                     fire;
    logic                     taken;

    assign cw    = cfb_pkg::ucode_rom(pc_reg);
    assign fire  = busy_reg && !(cw.emit && !out_free);
    assign taken = (cw.cond == cfb_pkg::COND_NODATA) && !has_data_reg;
    assign busy  = busy_reg;

    assign step = '{fire: fire, sel: cw.sel, emit: cw.emit, init: cw.init,
                    absorb: cw.absorb, last: cw.last};

    always_comb begin
        pc_next       = pc_reg;
        busy_next     = busy_reg;
        has_data_next = has_data_reg;
        if (start) begin
            pc_next       = cfb_pkg::UC_SYNC;
            busy_next     = 1'b1;
            has_data_next = has_data;
        end else if (fire) begin
            pc_next = taken ? cw.target : pc_reg + {{(cfb_pkg::PC_W-1){1'b0}}, 1'b1};
            if (cw.done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= cfb_pkg::UC_SYNC;
            busy_reg     <= 1'b0;
            has_data_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            busy_reg     <= busy_next;
            has_data_reg <= has_data_next;
        end
    end

endmodule

/* design/cfb_datapath.sv */
// ----------------------------------------------------------------------------
// cfb_datapath
// Command decode, frame word select, byte-wide CRC and output register.
// ----------------------------------------------------------------------------
module cfb_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfb_pkg::cfg_t       cfg,
    input  logic                load,      // latch a new command
    input  cfb_pkg::in_item_t   cmd,
    output logic                has_data,  // decode of cmd
    input  cfb_pkg::step_t      step,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output cfb_pkg::out_item_t  m_data
);

    logic [31:0]        addr_word_reg, addr_word_next;
    logic [31:0]        data_word_reg, data_word_next;
    logic [31:0]        shift_reg, shift_next;
    logic [31:0]        crc_reg, crc_next;
    logic               m_valid_reg, m_valid_next;
    cfb_pkg::out_item_t m_data_reg, m_data_next;
    logic [23:0]        addr_sel;
    logic [31:0]        word;
    logic [7:0]         crc_in_byte;
    logic [31:0]        crc_base;

    // Command decode
    always_comb begin
        addr_sel       = '0;
        data_word_next = cfb_pkg::READ_DATA;
        has_data       = 1'b1;
        unique case (cmd.opcode)
            cfb_pkg::OP_BATTERY:  addr_sel = cfg.battery_reg_addr;
            cfb_pkg::OP_RSSI:     addr_sel = cfg.rssi_reg_addr;
            cfb_pkg::OP_DISTANCE: addr_sel = cfg.distance_reg_addr;
            cfb_pkg::OP_AUTOFOCUS: begin
                addr_sel       = cfg.lens_motor_reg_addr;
                data_word_next = cfb_pkg::AUTOFOCUS_DATA;
            end
            cfb_pkg::OP_LENS_MOTOR: begin
                addr_sel       = cfg.lens_motor_reg_addr;
                data_word_next = cmd.argument[0] ? cfb_pkg::DATA_1_1 : cfb_pkg::DATA_1_2;
            end
            cfb_pkg::OP_BRACKET: begin
                addr_sel = cfg.bracket_reg_addr;
                unique case (cmd.argument)
                    cfb_pkg::DIR_UP:    data_word_next = cfb_pkg::DATA_1_1;
                    cfb_pkg::DIR_LEFT:  data_word_next = cfb_pkg::DATA_2_1;
                    cfb_pkg::DIR_RIGHT: data_word_next = cfb_pkg::DATA_2_2;
                    cfb_pkg::DIR_DOWN:  data_word_next = cfb_pkg::DATA_1_2;
                    default:            has_data       = 1'b0;
                endcase
            end
            cfb_pkg::OP_VOLUME: begin
                addr_sel       = cfg.volume_reg_addr;
                data_word_next = cmd.argument;
            end
            default: has_data = 1'b0;
        endcase
    end

    assign addr_word_next = {cfb_pkg::DEVICE_ADDR, addr_sel};

    // Frame word select
    always_comb begin
        unique case (step.sel)
            cfb_pkg::SEL_SYNC:  word = cfg.sync_word;
            cfb_pkg::SEL_LEN:   word = cfb_pkg::FRAME_LEN_WORD;
            cfb_pkg::SEL_NONCE: word = cfg.nonce_word;
            cfb_pkg::SEL_ADDR:  word = addr_word_reg;
            cfb_pkg::SEL_DATA:  word = data_word_reg;
            cfb_pkg::SEL_CRC:   word = ~crc_reg;
            default:            word = shift_reg;
        endcase
    end

    // Byte-serial CRC, top byte first
    assign crc_in_byte = word[31:24];
    assign crc_base    = step.init ? cfb_pkg::CRC_INIT : crc_reg;
    assign shift_next  = {word[23:0], 8'd0};
    assign crc_next    = cfb_pkg::crc_byte(crc_base, crc_in_byte);

    // Output register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (step.fire && step.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = '{frame_word: word, last_word: step.last};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            addr_word_reg <= addr_word_next;
            data_word_reg <= data_word_next;
        end
        if (step.fire) begin
            shift_reg <= shift_next;
            if (step.absorb) begin
                crc_reg <= crc_next;
            end
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/cfb_checker.sv */
// ----------------------------------------------------------------------------
// cfb_checker
// Port-level checks on the command frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module cfb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input cfb_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input cfb_pkg::out_item_t m_data,
    input logic               cfg_ready
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output changed while stalled");

    // a frame-producing command blocks the input next cycle
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode != cfb_pkg::OP_UNUSED) |=> !s_ready)
        else $error("input ready right after a frame command");

    // unused opcode leaves the input open
    a_unused_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == cfb_pkg::OP_UNUSED) |=> s_ready)
        else $error("unused opcode started a frame");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // config port always open
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind command_frame_builder_crc32 cfb_checker u_cfb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_ready (cfg_ready)
);
